### hdl/fpr_pkg.sv
// Shared constants and types for the framed packet receiver.
package fpr_pkg;

  localparam logic [7:0]  STX_BYTE      = 8'h02;
  localparam logic [7:0]  ETX_BYTE      = 8'h03;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam int          QUEUE_DEPTH   = 4;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_GOOD    = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       resync;
  } q_entry_t;

endpackage

### hdl/fpr_front.sv
// Front end: timeout register, idle tick counter and byte classification.
module fpr_front import fpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        q_full,
  output logic        q_push,
  output q_entry_t    q_entry
);

  logic [15:0] timeout_ticks;
  logic [15:0] idle_ticks;
  logic        tick_accept;

  assign cfg_ready   = 1'b1;
  assign in_ready    = !q_full;
  assign tick_accept = in_valid && in_ready && action;
  assign q_push      = in_valid && in_ready && !action;

  assign q_entry.data   = rx_byte;
  assign q_entry.resync = (idle_ticks >= timeout_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      idle_ticks    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
      // The count saturates at the timeout; a lowered timeout leaves it as is.
      if (q_push) begin
        idle_ticks <= '0;
      end else if (tick_accept && (idle_ticks < timeout_ticks)) begin
        idle_ticks <= idle_ticks + 16'd1;
      end
    end
  end

endmodule

### hdl/fpr_queue.sv
// Short queue of classified bytes between the front end and the parser.
module fpr_queue import fpr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t pop_entry,
  output logic     full,
  output logic     empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### hdl/fpr_back.sv
// Back end: frame parser state machine and the output register.
module fpr_back import fpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  q_entry_t    q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  command_code,
  output logic [7:0]  option_code,
  output logic [15:0] payload_length,
  output logic        aborted
);

  typedef enum logic [2:0] {
    WAIT_STX, WAIT_CMD, WAIT_OPT, WAIT_LEN_LO,
    WAIT_LEN_HI, WAIT_DATA, WAIT_SUM, WAIT_ETX
  } state_t;

  state_t      state, state_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  received_xor, received_xor_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  option_reg, option_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] byte_index, byte_index_next;
  logic [1:0]  kind_next;
  logic [7:0]  pbyte_next;
  logic [15:0] pidx_next;
  logic        abort_next;
  state_t      cur;
  logic [7:0]  b;

  assign q_pop = !q_empty && (!out_valid || out_ready);
  assign b     = q_entry.data;

  always_comb begin
    // A timed-out byte is handled as if the parser were waiting for STX.
    cur               = q_entry.resync ? WAIT_STX : state;
    abort_next        = q_entry.resync && (state != WAIT_STX);
    state_next        = cur;
    running_xor_next  = running_xor;
    received_xor_next = received_xor;
    command_reg_next  = command_reg;
    option_reg_next   = option_reg;
    length_reg_next   = length_reg;
    byte_index_next   = byte_index;
    kind_next         = KIND_HEADER;
    pbyte_next        = '0;
    pidx_next         = '0;
    case (cur)
      WAIT_STX: begin
        if (b == STX_BYTE) begin
          running_xor_next = '0;
          state_next       = WAIT_CMD;
        end
      end
      WAIT_CMD: begin
        command_reg_next = b;
        running_xor_next = running_xor ^ b;
        state_next       = WAIT_OPT;
      end
      WAIT_OPT: begin
        option_reg_next  = b;
        running_xor_next = running_xor ^ b;
        state_next       = WAIT_LEN_LO;
      end
      WAIT_LEN_LO: begin
        length_reg_next  = {8'h00, b};
        running_xor_next = running_xor ^ b;
        state_next       = WAIT_LEN_HI;
      end
      WAIT_LEN_HI: begin
        length_reg_next  = {b, length_reg[7:0]};
        running_xor_next = running_xor ^ b;
        if ({b, length_reg[7:0]} != 16'd0) begin
          byte_index_next = '0;
          state_next      = WAIT_DATA;
        end else begin
          state_next      = WAIT_SUM;
        end
      end
      WAIT_DATA: begin
        kind_next        = KIND_PAYLOAD;
        pbyte_next       = b;
        pidx_next        = byte_index;
        running_xor_next = running_xor ^ b;
        byte_index_next  = byte_index + 16'd1;
        if ((byte_index + 16'd1) == length_reg) begin
          state_next = WAIT_SUM;
        end
      end
      WAIT_SUM: begin
        received_xor_next = b;
        state_next        = WAIT_ETX;
      end
      WAIT_ETX: begin
        kind_next  = ((b == ETX_BYTE) && (running_xor == received_xor)) ? KIND_GOOD
                                                                          : KIND_BAD;
        state_next = WAIT_STX;
      end
      default: begin
        state_next = WAIT_STX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= WAIT_STX;
      running_xor  <= '0;
      received_xor <= '0;
      command_reg  <= '0;
      option_reg   <= '0;
      length_reg   <= '0;
      byte_index   <= '0;
      out_valid    <= 1'b0;
    end else if (q_pop) begin
      state        <= state_next;
      running_xor  <= running_xor_next;
      received_xor <= received_xor_next;
      command_reg  <= command_reg_next;
      option_reg   <= option_reg_next;
      length_reg   <= length_reg_next;
      byte_index   <= byte_index_next;
      out_valid    <= 1'b1;
    end else if (out_ready) begin
      out_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      event_kind     <= kind_next;
      payload_byte   <= pbyte_next;
      payload_index  <= pidx_next;
      command_code   <= command_reg_next;
      option_code    <= option_reg_next;
      payload_length <= length_reg_next;
      aborted        <= abort_next;
    end
  end

endmodule

### hdl/framed_packet_receiver.sv
// Top level of the framed packet receiver: front end, byte queue and parser.
// An accepted byte is written into the queue and then into the output register.
// Throughput: one beat per cycle in and out while out_ready is high; ticks need no slot.
// The queue (QUEUE_DEPTH_P entries) and the output register absorb output stalls.
// Reset (rst, synchronous) empties the queue and output, sets the timeout to 100
// and puts the parser in the wait-for-STX state with all registers cleared.
module framed_packet_receiver import fpr_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  command_code,
  output logic [7:0]  option_code,
  output logic [15:0] payload_length,
  output logic        aborted
);

  q_entry_t push_entry;
  q_entry_t pop_entry;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  fpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  fpr_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  fpr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .command_code   (command_code),
    .option_code    (option_code),
    .payload_length (payload_length),
    .aborted        (aborted)
  );

endmodule

### hdl/fpr_checker.sv
// Port-level assertions for the framed packet receiver, bound to the top level.
module fpr_port_checks import fpr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [7:0]  payload_byte,
  input logic [15:0] payload_index,
  input logic [15:0] payload_length,
  input logic        aborted
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind)
      && $stable(payload_byte) && $stable(payload_index))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Payload beats always fall inside the declared length.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_PAYLOAD |-> payload_index < payload_length)
    else $error("payload index beyond declared length");

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != KIND_PAYLOAD |-> payload_byte == 8'd0
      && payload_index == 16'd0)
    else $error("payload fields set on a non-payload beat");

  // An aborted frame restarts the parser, so that byte is a header-class beat.
  a_abort_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && aborted |-> event_kind == KIND_HEADER)
    else $error("aborted beat with a payload or end-of-frame kind");

endmodule

bind framed_packet_receiver fpr_port_checks u_fpr_port_checks (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_kind     (event_kind),
  .payload_byte   (payload_byte),
  .payload_index  (payload_index),
  .payload_length (payload_length),
  .aborted        (aborted)
);
